/* rtl/kvt_pkg.sv */
`timescale 1ns / 1ps

package kvt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int NAME_BYTES  = 8;
    localparam int VALUE_WIDTH = 32;

    localparam int NAME_W = 8 * NAME_BYTES;
    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    // port field widths
    localparam int KEY_FIELD_W  = 64;
    localparam int WVAL_FIELD_W = 32;
    localparam int RVAL_FIELD_W = 32;
    localparam int SLOT_W       = 7;
    localparam int STATUS_W     = 2;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } kvt_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } kvt_status_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } kvt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic more;
        logic pend;
        logic match;
        logic out_free;
    } kvt_sts_t;

endpackage

/* rtl/kvt_ctrl.sv */
`timescale 1ns / 1ps

module kvt_ctrl
    import kvt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  kvt_sts_t sts,
    output kvt_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.match || (!sts.pend && !sts.more)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/kvt_datapath.sv */
`timescale 1ns / 1ps

module kvt_datapath
    import kvt_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  kvt_cmd_t                cmd,
    output kvt_sts_t                sts,
    input  logic                    in_op,
    input  logic [KEY_FIELD_W-1:0]  in_key,
    input  logic [WVAL_FIELD_W-1:0] in_wval,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [STATUS_W-1:0]     out_status,
    output logic [RVAL_FIELD_W-1:0] out_rval,
    output logic [SLOT_W-1:0]       out_slot
);

    logic [NAME_W-1:0]      name_mem  [TABLE_DEPTH];
    logic [VALUE_WIDTH-1:0] value_mem [TABLE_DEPTH];

    logic                   op_reg;
    logic [NAME_W-1:0]      key_reg;
    logic [VALUE_WIDTH-1:0] wval_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       scan_idx_reg;
    logic                   pend_reg;
    logic [IDX_W-1:0]       pend_idx_reg;
    logic [NAME_W-1:0]      name_rd_reg;
    logic [VALUE_WIDTH-1:0] value_rd_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic [VALUE_WIDTH-1:0] hit_value_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [RVAL_FIELD_W-1:0] out_rval_reg;
    logic [SLOT_W-1:0]      out_slot_reg;

    logic                   rd_en;
    logic                   match;
    logic                   table_full;
    logic                   wr_en;
    logic                   wr_name;
    logic [IDX_W-1:0]       wr_addr;
    kvt_status_t            res_status;
    logic [RVAL_FIELD_W-1:0] res_rval;
    logic [CNT_W-1:0]       res_slot;

    assign match      = pend_reg && (name_rd_reg == key_reg);
    assign rd_en      = cmd.scan && !match && (scan_idx_reg < count_reg);
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));

    assign sts.more     = (scan_idx_reg < count_reg);
    assign sts.pend     = pend_reg;
    assign sts.match    = match;
    assign sts.out_free = !out_valid_reg || out_ready;

    // result and table update for the finishing request
    always_comb begin
        res_status = STATUS_DONE;
        res_rval   = '0;
        res_slot   = count_reg;
        wr_en      = 1'b0;
        wr_name    = 1'b0;
        wr_addr    = count_reg[IDX_W-1:0];
        count_next = count_reg;
        if (hit_reg) begin
            res_slot = CNT_W'(hit_idx_reg);
        end
        if (op_reg == OP_READ) begin
            if (hit_reg) begin
                res_rval = RVAL_FIELD_W'(hit_value_reg);
            end else begin
                res_status = STATUS_NOT_FOUND;
            end
        end else begin
            if (hit_reg) begin
                wr_en   = cmd.commit;
                wr_addr = hit_idx_reg;
            end else if (!table_full) begin
                wr_en   = cmd.commit;
                wr_name = cmd.commit;
                if (cmd.commit) begin
                    count_next = count_reg + 1'b1;
                end
            end else begin
                res_status = STATUS_FULL;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            name_rd_reg  <= name_mem[scan_idx_reg[IDX_W-1:0]];
            value_rd_reg <= value_mem[scan_idx_reg[IDX_W-1:0]];
        end
        if (wr_en) begin
            value_mem[wr_addr] <= wval_reg;
        end
        if (wr_name) begin
            name_mem[wr_addr] <= key_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cmd.load) begin
                scan_idx_reg <= '0;
                pend_reg     <= 1'b0;
                hit_reg      <= 1'b0;
            end else if (cmd.scan) begin
                if (match) begin
                    hit_reg  <= 1'b1;
                    pend_reg <= 1'b0;
                end else begin
                    pend_reg <= rd_en;
                    if (rd_en) begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_op;
            key_reg  <= in_key[NAME_W-1:0];
            wval_reg <= VALUE_WIDTH'(in_wval);
        end
        if (rd_en) begin
            pend_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (cmd.scan && match) begin
            hit_idx_reg   <= pend_idx_reg;
            hit_value_reg <= value_rd_reg;
        end
        if (cmd.commit) begin
            out_status_reg <= res_status;
            out_rval_reg   <= res_rval;
            out_slot_reg   <= SLOT_W'(res_slot);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_rval   = out_rval_reg;
    assign out_slot   = out_slot_reg;

endmodule

/* rtl/keyed_variable_table_unit.sv */
`timescale 1ns / 1ps

// keyed variable table: a store of up to 64 name/value pairs, names of up to eight
// zero-padded bytes, values of 32 bits. each input transaction is a read (tuser 0)
// or a write (tuser 1) and yields exactly one result transaction with a status,
// the read value and the slot. live entries are scanned in slot order through one
// read port of the name and value memories, one entry per cycle, and the first
// equal name wins; a write updates that entry or appends at the entry count, and
// a write of a new name into a full table is refused with status 2. the scan over
// the single memory read port plus the compare of the last entry read sets how
// long a request takes. the next request is taken only once the previous result
// has been written, and may be taken while that result still waits in the output
// register. names and values come up undefined after reset, but only slots below
// the entry count (cleared by reset) are ever read, so no clearing pass is needed.

module keyed_variable_table_unit
    import kvt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // key_name [63:0], write_value [95:64]
    input  logic         s_tuser,   // op [0]: 0 read, 1 write
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata    // status [1:0], read_value [33:2], slot_index [40:34], zero
);

    kvt_cmd_t cmd;
    kvt_sts_t sts;

    logic [STATUS_W-1:0]     out_status;
    logic [RVAL_FIELD_W-1:0] out_rval;
    logic [SLOT_W-1:0]       out_slot;

    // sequencer: accept, scan, finish
    kvt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // memories, entry count, scan pointer and output register
    kvt_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tuser),
        .in_key     (s_tdata[63:0]),
        .in_wval    (s_tdata[95:64]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_rval   (out_rval),
        .out_slot   (out_slot)
    );

    // pack the result fields, lowest field first, padded to whole bytes
    assign m_tdata = {7'd0, out_slot, out_rval, out_status};

    // a result is only written when the output register is free or draining
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("result written over a pending transaction");

    // a result is presented the cycle after it is written
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("finished request produced no result");

    // after accepting a request the block stays busy until its result is written
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in progress");

    // the status code is never the unused encoding
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("undefined status code on result");

endmodule

/* bench/tb_keyed_variable_table_unit.sv */
`timescale 1ns / 1ps

module tb_keyed_variable_table_unit;
    import kvt_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PER_PHASE = 150;
    // longest scan plus margin, waited out once the last reply is in
    localparam int DRAIN_CYCLES  = 2 * (TABLE_DEPTH + 4);
    localparam logic [31:0] VALUE_MASK =
        (VALUE_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << VALUE_WIDTH) - 1);
    localparam logic [63:0] NAME_MASK =
        (NAME_W >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << NAME_W) - 1);

    typedef struct {
        kvt_op_t     op;
        logic [63:0] key_name;
        logic [31:0] write_value;
    } table_request_t;

    typedef struct {
        kvt_status_t status;
        logic [31:0] read_value;
        logic [6:0]  slot_index;
    } table_reply_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata  = '0;   // key_name [63:0], write_value [95:64]
    logic         s_tuser  = 1'b0; // op [0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;         // status [1:0], read_value [33:2], slot_index [40:34]

    keyed_variable_table_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    table_request_t pending_requests[$];
    table_reply_t   expected_replies[$];
    logic [63:0]    issued_names[$];     // names sent in writes, used to aim reads

    // table model state
    logic [63:0] model_names[TABLE_DEPTH];
    logic [31:0] model_values[TABLE_DEPTH];
    int          model_count = 0;

    int gap_pct   = 0;
    int stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;
    int queued_total = 0;
    int reply_total = 0;
    int read_total = 0, read_miss_total = 0;
    int write_total = 0, write_append_total = 0, write_refused_total = 0;

    function automatic void note_error(string msg);
        if (error_count < 10)
            $display("mismatch @%0t: %s", $realtime, msg);
        error_count++;
    endfunction

    // first matching live slot wins; a miss points at the entry count
    function automatic void predict_table_access(table_request_t req);
        logic [63:0]  key;
        logic [31:0]  val;
        int           slot;
        table_reply_t reply;
        key  = req.key_name & NAME_MASK;
        val  = req.write_value & VALUE_MASK;
        slot = model_count;
        for (int i = model_count - 1; i >= 0; i--)
            if (model_names[i] == key)
                slot = i;
        reply.status     = STATUS_DONE;
        reply.read_value = '0;
        reply.slot_index = 7'(slot);
        if (req.op == OP_READ) begin
            read_total++;
            if (slot == model_count) begin
                reply.status = STATUS_NOT_FOUND;
                read_miss_total++;
            end else begin
                reply.read_value = model_values[slot];
            end
        end else begin
            write_total++;
            if (slot < model_count) begin
                model_values[slot] = val;
            end else if (model_count < TABLE_DEPTH) begin
                model_names[model_count]  = key;
                model_values[model_count] = val;
                model_count++;
                write_append_total++;
            end else begin
                reply.status = STATUS_FULL;
                write_refused_total++;
            end
        end
        expected_replies.push_back(reply);
    endfunction

    task automatic queue_request(kvt_op_t op, logic [63:0] key, logic [31:0] val);
        table_request_t req;
        req.op          = op;
        req.key_name    = key;
        req.write_value = val;
        pending_requests.push_back(req);
        queued_total++;
        if (op == OP_WRITE)
            issued_names.push_back(key);
    endtask

    // request driver: predicts on acceptance, then offers the next queued request
    always @(posedge aclk) begin : request_drive
        table_request_t on_bus;
        table_request_t next_req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_table_access(on_bus);
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    next_req = pending_requests.pop_front();
                    on_bus   = next_req;
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_req.op;
                    s_tdata  <= {next_req.write_value, next_req.key_name};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // reply monitor with random back-pressure
    always @(posedge aclk) begin : reply_check
        table_reply_t want;
        logic [1:0]   got_status;
        logic [31:0]  got_value;
        logic [6:0]   got_slot;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
            if (m_tvalid && m_tready) begin
                got_status = m_tdata[1:0];
                got_value  = m_tdata[33:2];
                got_slot   = m_tdata[40:34];
                if (expected_replies.size() == 0) begin
                    note_error($sformatf("unexpected reply status %0d value %h slot %0d",
                                         got_status, got_value, got_slot));
                end else begin
                    want = expected_replies.pop_front();
                    reply_total++;
                    if (got_status !== want.status)
                        note_error($sformatf("status exp %0d got %0d",
                                             want.status, got_status));
                    if (got_value !== want.read_value)
                        note_error($sformatf("read_value exp %h got %h",
                                             want.read_value, got_value));
                    if (got_slot !== want.slot_index)
                        note_error($sformatf("slot_index exp %0d got %0d",
                                             want.slot_index, got_slot));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, queued_total - reply_total);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int unsigned pick;
        logic [63:0] key;
        logic [31:0] val;

        // directed: empty table, extreme names and values, updates, near misses
        queue_request(OP_READ,  64'h0, 32'h0);
        queue_request(OP_READ,  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(OP_WRITE, 64'h0, 32'h0);
        queue_request(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(OP_READ,  64'h0, 32'h0);
        queue_request(OP_READ,  64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        queue_request(OP_WRITE, 64'h0, 32'hA5A5_A5A5);
        queue_request(OP_READ,  64'h0, 32'h0);
        // differs from the zero name only in the top byte
        queue_request(OP_WRITE, 64'h8000_0000_0000_0000, 32'h5A5A_5A5A);
        queue_request(OP_WRITE, 64'h0000_0000_0000_0001, 32'h0000_0001);
        queue_request(OP_READ,  64'h0000_0000_0000_0100, 32'h0);
        queue_request(OP_READ,  64'h8000_0000_0000_0000, 32'h0);
        // zero padded ascii name
        queue_request(OP_WRITE, 64'h0072_6574_6E75_6F63, 32'h7FFF_FFFF);
        queue_request(OP_READ,  64'h0072_6574_6E75_6F63, 32'h0);
        // write_value must be ignored on a read
        queue_request(OP_READ,  64'h0000_0000_0000_0001, 32'hDEAD_BEEF);
        queue_request(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
        queue_request(OP_READ,  64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678);
        queue_request(OP_READ,  64'h7FFF_FFFF_FFFF_FFFF, 32'h0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // random phases: steady, sender gaps, receiver stalls, both
        // new names fill the table well before the end, so full-table writes follow
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 50; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 50; end
                default: begin gap_pct = 20; stall_pct = 20; end
            endcase
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                pick = $urandom_range(99);
                case ($urandom_range(7))
                    0:       val = 32'h0;
                    1:       val = 32'hFFFF_FFFF;
                    default: val = $urandom;
                endcase
                if (pick < 25 || issued_names.size() == 0) begin
                    queue_request(OP_WRITE, {$urandom, $urandom}, val);
                end else begin
                    key = issued_names[$urandom_range(issued_names.size() - 1)];
                    if (pick < 50)
                        queue_request(OP_WRITE, key, val);
                    else if (pick < 85)
                        queue_request(OP_READ, key, val);
                    else if (pick < 93)
                        queue_request(OP_READ, key ^ (64'd1 << $urandom_range(63)), val);
                    else
                        queue_request(OP_READ, {$urandom, $urandom}, val);
                end
            end
            while (pending_requests.size() != 0)
                @(posedge aclk);
        end

        // every queued request must come back before the final check
        while (reply_total < queued_total)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_replies.size() != 0)
            note_error($sformatf("%0d replies never arrived", expected_replies.size()));
        $display("covered %0d reads (%0d misses), %0d writes (%0d appends, %0d refused full)",
                 read_total, read_miss_total, write_total, write_append_total,
                 write_refused_total);
        $display("table ended with %0d of %0d slots live, %0d mismatches",
                 model_count, TABLE_DEPTH, error_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
